// ----- rtl/hep_pkg.sv -----
`timescale 1ns / 1ps
package hep_pkg;

   localparam int SYM_W     = 8;
   localparam int WORD_W    = 32;
   localparam int LEN_W     = 6;
   localparam int KIND_W    = 2;
   localparam int BYTE_BITS = 8;
   localparam int PAD_W     = 3;
   localparam int PEND_W    = 7;
   localparam int ACC_W     = PEND_W + WORD_W;
   localparam int CNT_W     = 6;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_FLUSH  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [WORD_W-1:0] word;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              valid;
      logic              is_flush;
      logic [LEN_W-1:0]  len;
      logic [WORD_W-1:0] word;
   } item_type;

endpackage

// ----- rtl/hep_if.sv -----
`timescale 1ns / 1ps
interface hep_req_if;
   import hep_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SYM_W-1:0]  symbol;
   logic [WORD_W-1:0] code_word;
   logic [LEN_W-1:0]  code_length;

   modport source (output valid, output kind, output symbol, output code_word,
                   output code_length, input ready);
   modport sink   (input valid, input kind, input symbol, input code_word,
                   input code_length, output ready);
endinterface

interface hep_rsp_if;
   import hep_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] out_byte;
   logic [PAD_W-1:0]     pad_count;
   logic                 last;

   modport source (output valid, output out_byte, output pad_count, output last,
                   input ready);
   modport sink   (input valid, input out_byte, input pad_count, input last,
                   output ready);
endinterface

// ----- rtl/hep_ram.sv -----
`timescale 1ns / 1ps
module hep_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/hep_lookup.sv -----
`timescale 1ns / 1ps
module hep_lookup #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic              clock,
   input  logic              reset,
   hep_req_if.sink           req_chan,
   output hep_pkg::item_type item,
   input  logic              take
);
   import hep_pkg::*;

   localparam int IDX_W   = $clog2(SYMBOL_COUNT);
   localparam int LEN_LIM = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;

   logic                    accept;
   logic                    in_range;
   logic [IDX_W-1:0]        addr;
   logic                    is_load;
   logic                    is_encode;
   logic                    is_flush;
   logic [LEN_W-1:0]        len_clamped;
   logic [WORD_W-1:0]       word_mask;
   entry_type               wr_entry;
   entry_type               rd_entry;
   logic                    wr_en;
   logic                    rd_en;
   logic [SYMBOL_COUNT-1:0] valid_ff;
   logic [SYMBOL_COUNT-1:0] valid_in;
   logic                    hit_ff;
   logic                    stage_valid_ff;
   logic                    stage_valid_in;
   logic                    stage_flush_ff;

   assign req_chan.ready = !stage_valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_range       = {1'b0, req_chan.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
   assign addr           = req_chan.symbol[IDX_W-1:0];

   always_comb begin
      is_load   = 1'b0;
      is_encode = 1'b0;
      is_flush  = 1'b0;
      unique case (kind_type'(req_chan.kind))
         KIND_LOAD:   is_load   = 1'b1;
         KIND_ENCODE: is_encode = 1'b1;
         KIND_FLUSH:  is_flush  = 1'b1;
         default: ;
      endcase
   end

   // saturate length, drop code bits above it
   always_comb begin
      if (req_chan.code_length > LEN_W'(LEN_LIM)) begin
         len_clamped = LEN_W'(LEN_LIM);
      end else begin
         len_clamped = req_chan.code_length;
      end
      if (len_clamped >= LEN_W'(WORD_W)) begin
         word_mask = '1;
      end else begin
         word_mask = WORD_W'(((WORD_W + 1)'(1) << len_clamped) - (WORD_W + 1)'(1));
      end
      wr_entry.len  = len_clamped;
      wr_entry.word = req_chan.code_word & word_mask;
   end

   assign wr_en = accept && is_load && in_range;
   assign rd_en = accept && is_encode && in_range;

   hep_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[addr] = 1'b1;
      end
      if (accept) begin
         stage_valid_in = (is_encode && in_range) || is_flush;
      end else if (take) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         stage_valid_ff <= stage_valid_in;
      end
      if (accept) begin
         stage_flush_ff <= is_flush;
      end
      if (rd_en) begin
         hit_ff <= valid_ff[addr];
      end
   end

   // entries never loaded read as length zero
   always_comb begin
      item.valid    = stage_valid_ff;
      item.is_flush = stage_flush_ff;
      item.len      = (hit_ff && !stage_flush_ff) ? rd_entry.len : '0;
      item.word     = (hit_ff && !stage_flush_ff) ? rd_entry.word : '0;
   end

endmodule

// ----- rtl/hep_packer.sv -----
`timescale 1ns / 1ps
module hep_packer (
   input  logic              clock,
   input  logic              reset,
   input  hep_pkg::item_type item,
   output logic              take,
   hep_rsp_if.source         rsp_chan
);
   import hep_pkg::*;

   logic [ACC_W-1:0]     acc_ff;
   logic [ACC_W-1:0]     acc_in;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic [CNT_W-1:0]     cnt_after;
   logic                 flush_ff;
   logic                 flush_in;
   logic                 flush_after;
   logic                 out_free;
   logic                 emit;
   logic [PAD_W-1:0]     pad;
   logic [BYTE_BITS-1:0] byte_sel;
   logic                 last_sel;
   logic                 rsp_valid_ff;
   logic [BYTE_BITS-1:0] rsp_byte_ff;
   logic [PAD_W-1:0]     rsp_pad_ff;
   logic                 rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = out_free && (flush_ff || cnt_ff >= CNT_W'(BYTE_BITS));
   assign pad      = PAD_W'(CNT_W'(BYTE_BITS) - cnt_ff);

   always_comb begin
      if (flush_ff) begin
         byte_sel = acc_ff[BYTE_BITS-1:0] << pad;
         last_sel = 1'b1;
      end else begin
         byte_sel = BYTE_BITS'(acc_ff >> (cnt_ff - CNT_W'(BYTE_BITS)));
         last_sel = cnt_ff < CNT_W'(2 * BYTE_BITS);
      end
   end

   always_comb begin
      cnt_after   = cnt_ff;
      flush_after = flush_ff;
      if (emit) begin
         flush_after = 1'b0;
         if (flush_ff) begin
            cnt_after = '0;
         end else begin
            cnt_after = cnt_ff - CNT_W'(BYTE_BITS);
         end
      end
      take     = item.valid && !flush_after && (cnt_after < CNT_W'(BYTE_BITS));
      acc_in   = acc_ff;
      cnt_in   = cnt_after;
      flush_in = flush_after;
      if (take) begin
         if (item.is_flush) begin
            flush_in = cnt_after != '0;
         end else begin
            acc_in = (acc_ff << item.len) | ACC_W'(item.word);
            cnt_in = cnt_after + item.len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         flush_ff <= flush_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      acc_ff <= acc_in;
      if (emit) begin
         rsp_byte_ff <= byte_sel;
         rsp_pad_ff  <= flush_ff ? pad : '0;
         rsp_last_ff <= last_sel;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_byte  = rsp_byte_ff;
   assign rsp_chan.pad_count = rsp_pad_ff;
   assign rsp_chan.last      = rsp_last_ff;

endmodule

// ----- rtl/huffman_encoder_bit_packer.sv -----
`timescale 1ns / 1ps
// a response byte passes the table read and lookup stage registers, the bit buffer and the output register
// throughput: one request per cycle while each encode yields at most one byte and the
// receiver is ready; an encode that yields more bytes holds the packer until they are out
// reset clears the bit buffer and the per-entry valid bits of the code table,
// so every entry reads as length zero until loaded; no clearing pass is needed
module huffman_encoder_bit_packer #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic      clock,
   input  logic      reset,
   hep_req_if.sink   req_chan,
   hep_rsp_if.source rsp_chan
);
   import hep_pkg::*;

   item_type item;
   logic     take;

   hep_lookup #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_lookup (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .item     (item),
      .take     (take)
   );

   hep_packer u_packer (
      .clock    (clock),
      .reset    (reset),
      .item     (item),
      .take     (take),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- dv/huffman_encoder_bit_packer_tb.sv -----
`timescale 1ns / 1ps
module huffman_encoder_bit_packer_tb;
   import hep_pkg::*;

   localparam int MAX_LEN = 32;
   localparam int SYMBOLS = 256;
   localparam int RANDOM_REQUESTS = 200;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 100;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic              drain;
      logic [KIND_W-1:0] kind;
      logic [SYM_W-1:0]  symbol;
      logic [WORD_W-1:0] code_word;
      logic [LEN_W-1:0]  code_length;
   } request_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic [PAD_W-1:0]     pad_count;
      logic                 last;
   } packed_byte_type;

   logic clock = 1'b0;
   logic reset;

   hep_req_if req ();
   hep_rsp_if rsp ();

   huffman_encoder_bit_packer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [WORD_W-1:0] code_words [SYMBOLS] = '{default: '0};
   int                code_lens  [SYMBOLS] = '{default: 0};
   logic [PEND_W-1:0] held_bits = '0;
   int                held_count = 0;

   request_type     request_q [$];
   packed_byte_type byte_q [$];
   request_type     cur_req;
   request_type     next_req;
   packed_byte_type want;
   int              error_count = 0;
   int              sent_count = 0;
   int              rcvd_count = 0;
   int              hold_left = 0;
   int              idle_cycles = 0;
   logic [SYM_W-1:0] sym_pool [16];

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic pack_request(input request_type r);
      logic [ACC_W-1:0]     acc;
      logic [ACC_W-1:0]     shifted;
      logic [BYTE_BITS-1:0] flushed;
      packed_byte_type      e;
      int                   len;
      int                   total;
      int                   pad;
      case (r.kind)
         KIND_LOAD: begin
            len = r.code_length;
            if (len > MAX_LEN) len = MAX_LEN;
            code_lens[r.symbol] = len;
            if (len < WORD_W)
               code_words[r.symbol] = r.code_word & ((32'd1 << len) - 32'd1);
            else
               code_words[r.symbol] = r.code_word;
         end
         KIND_ENCODE: begin
            len = code_lens[r.symbol];
            if (len != 0) begin
               acc = ({32'd0, held_bits} << len) | {7'd0, code_words[r.symbol]};
               total = held_count + len;
               while (total >= BYTE_BITS) begin
                  shifted = acc >> (total - BYTE_BITS);
                  e.out_byte = shifted[BYTE_BITS-1:0];
                  e.pad_count = '0;
                  total -= BYTE_BITS;
                  e.last = (total < BYTE_BITS);
                  byte_q = {byte_q, e};
               end
               held_count = total;
               held_bits = acc[PEND_W-1:0] & ((7'd1 << total) - 7'd1);
            end
         end
         KIND_FLUSH: begin
            if (held_count != 0) begin
               pad = BYTE_BITS - held_count;
               flushed = {1'b0, held_bits} << pad;
               e.out_byte = flushed;
               e.pad_count = pad[PAD_W-1:0];
               e.last = 1'b1;
               byte_q = {byte_q, e};
               held_bits = '0;
               held_count = 0;
            end
         end
         default: ;
      endcase
   endtask

   function automatic void add_request(input logic [KIND_W-1:0] kind,
                                       input logic [SYM_W-1:0] symbol,
                                       input logic [WORD_W-1:0] code_word,
                                       input logic [LEN_W-1:0] code_length);
      request_type r;
      r.drain = 1'b0;
      r.kind = kind;
      r.symbol = symbol;
      r.code_word = code_word;
      r.code_length = code_length;
      request_q = {request_q, r};
   endfunction

   function automatic void add_drain();
      request_type r;
      r = '0;
      r.drain = 1'b1;
      request_q = {request_q, r};
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.kind <= KIND_LOAD;
         req.symbol <= '0;
         req.code_word <= '0;
         req.code_length <= '0;
      end else begin
         if (req.valid && req.ready) begin
            pack_request(cur_req);
            sent_count++;
         end
         if (!req.valid || req.ready) begin
            if (request_q.size() > 0 && request_q[0].drain && byte_q.size() == 0)
               void'(request_q.pop_front());
            if (request_q.size() > 0 && !request_q[0].drain &&
                ((sent_count >= 60 && sent_count < 140) || $urandom_range(0, 99) >= 6)) begin
               next_req = request_q.pop_front();
               cur_req <= next_req;
               req.valid <= 1'b1;
               req.kind <= next_req.kind;
               req.symbol <= next_req.symbol;
               req.code_word <= next_req.code_word;
               req.code_length <= next_req.code_length;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            rcvd_count++;
            if (byte_q.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h", rsp.out_byte));
            end else begin
               want = byte_q.pop_front();
               if (rsp.out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %02h, expected %02h",
                                            rsp.out_byte, want.out_byte));
               if (rsp.pad_count !== want.pad_count)
                  report_mismatch($sformatf("pad_count %0d, expected %0d",
                                            rsp.pad_count, want.pad_count));
               if (rsp.last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp.last, want.last));
            end
            if (rcvd_count == 30) hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= (rcvd_count >= 80 && rcvd_count < 180) ||
                         $urandom_range(0, 99) >= 6;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      int count;
      int len;
      logic [SYM_W-1:0] sym;

      reset = 1'b1;

      // unloaded symbol and empty flush
      add_request(KIND_ENCODE, 8'd0, 32'd0, 6'd0);
      add_request(KIND_FLUSH, 8'd0, 32'd0, 6'd0);
      add_request(KIND_LOAD, 8'd0, 32'hffff_ffff, 6'd32);
      add_request(KIND_LOAD, 8'd255, 32'h0000_0000, 6'd1);
      // stray bits above the length
      add_request(KIND_LOAD, 8'd1, 32'hffff_ffff, 6'd5);
      // overlong lengths saturate
      add_request(KIND_LOAD, 8'd2, 32'h1234_5678, 6'd63);
      add_request(KIND_LOAD, 8'd3, 32'habcd_ef01, 6'd33);
      add_request(KIND_LOAD, 8'd4, 32'h0000_ffff, 6'd0);
      add_request(KIND_ENCODE, 8'd255, 32'd0, 6'd0);
      add_request(KIND_ENCODE, 8'd0, 32'd0, 6'd0);
      add_request(KIND_ENCODE, 8'd1, 32'd0, 6'd0);
      add_request(KIND_ENCODE, 8'd4, 32'd0, 6'd0);
      add_request(KIND_ENCODE, 8'd2, 32'd0, 6'd0);
      add_request(KIND_FLUSH, 8'd0, 32'd0, 6'd0);
      add_request(KIND_FLUSH, 8'd255, 32'hffff_ffff, 6'd63);
      add_request(KIND_UNUSED, 8'd255, 32'hffff_ffff, 6'd63);
      add_request(KIND_ENCODE, 8'd3, 32'd0, 6'd0);
      add_request(KIND_FLUSH, 8'd0, 32'd0, 6'd0);
      add_request(KIND_LOAD, 8'd128, 32'h0000_0055, 6'd7);
      add_request(KIND_LOAD, 8'd129, 32'h0000_00a5, 6'd8);
      add_request(KIND_ENCODE, 8'd128, 32'd0, 6'd0);
      add_request(KIND_FLUSH, 8'd0, 32'd0, 6'd0);
      add_request(KIND_ENCODE, 8'd129, 32'd0, 6'd0);
      add_request(KIND_ENCODE, 8'd255, 32'd0, 6'd0);
      add_request(KIND_FLUSH, 8'd0, 32'd0, 6'd0);
      add_drain();

      for (int i = 0; i < 16; i++) sym_pool[i] = SYM_W'($urandom_range(0, 255));
      for (int i = 0; i < 16; i++) begin
         len = $urandom_range(1, 20);
         add_request(KIND_LOAD, sym_pool[i], $urandom, len[LEN_W-1:0]);
      end

      count = 0;
      while (count < RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 80) sym = sym_pool[4'($urandom_range(0, 15))];
         else sym = SYM_W'($urandom_range(0, 255));
         if (pick < 15) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) len = $urandom_range(1, 16);
            else if (pick < 85) len = $urandom_range(17, 32);
            else if (pick < 92) len = 0;
            else len = $urandom_range(33, 63);
            add_request(KIND_LOAD, sym, $urandom, len[LEN_W-1:0]);
            count++;
         end else if (pick < 87) begin
            add_request(KIND_ENCODE, sym, $urandom, LEN_W'($urandom_range(0, 63)));
            count++;
         end else if (pick < 96) begin
            add_request(KIND_FLUSH, sym, $urandom, LEN_W'($urandom_range(0, 63)));
            count++;
         end else begin
            add_request(KIND_UNUSED, sym, $urandom, LEN_W'($urandom_range(0, 63)));
         end
         if (count == 150) add_drain();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (request_q.size() != 0 || req.valid) @(negedge clock);
      while (byte_q.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0 && byte_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
